// File: rtl/core/sfd_pkg.sv
// package for the scale frame decoder
// frame codes, byte positions, result type and stream widths; no dependencies
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] STX_CODE   = 8'h02;
  localparam logic [7:0] ETX_CODE   = 8'h03;
  localparam logic [7:0] CR_CODE    = 8'h0D;
  localparam logic [7:0] TARE_MARK  = 8'h54;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [2:0] DECIMAL_MASK = 3'h7;

  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_IDLE       = 5'd0;
  localparam logic [POS_W-1:0] POS_WEIGHT_END = 5'd6;
  localparam logic [POS_W-1:0] POS_STATUS     = 5'd8;
  localparam logic [POS_W-1:0] POS_ETX        = 5'd9;
  localparam logic [POS_W-1:0] POS_CHECKSUM   = 5'd10;
  localparam logic [POS_W-1:0] POS_CR         = 5'd11;
  localparam logic [POS_W-1:0] POS_TARE_MARK  = 5'd12;
  localparam logic [POS_W-1:0] POS_TARE_FIRST = 5'd13;
  localparam logic [POS_W-1:0] POS_TARE_END   = 5'd17;
  localparam logic [POS_W-1:0] POS_LAST       = 5'd18;

  localparam int unsigned WEIGHT_ACC_W = 20;
  localparam int unsigned WEIGHT_W     = 21;
  localparam int unsigned TARE_W       = 17;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_value;
    logic [TARE_W-1:0]          tare_value;
    logic [2:0]                 decimals;
    logic                       over_max;
    logic                       under_min;
    logic                       is_stable;
    logic                       is_zero;
    logic                       tare_present;
    logic                       frame_valid;
  } sfd_result_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfd_frame_parse.sv
// frame parser: byte position, checksum and digit accumulators
// one byte per enable; uses sfd_pkg
`default_nettype none

module sfd_frame_parse
  import sfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [7:0]  byte_i,
  output logic             last_o,
  output sfd_result_t      result_o
);

  logic [POS_W-1:0]        pos_q, pos_d;
  logic [7:0]              sum_q, sum_d;
  logic [WEIGHT_ACC_W-1:0] wacc_q, wacc_d;
  logic                    wneg_q, wneg_d;
  logic [TARE_W-1:0]       tacc_q, tacc_d;
  logic [7:0]              status_q, status_d;
  logic                    hdr_good_q, hdr_good_d;
  logic                    dig_err_q, dig_err_d;
  logic                    tare_good_q, tare_good_d;

  logic [3:0]              digit;
  logic [WEIGHT_ACC_W-1:0] wacc_next;
  logic [TARE_W-1:0]       tacc_next;

  assign digit     = 4'(byte_i - ZERO_CHAR);
  assign wacc_next = (wacc_q << 3) + (wacc_q << 1) + WEIGHT_ACC_W'(digit);
  assign tacc_next = (tacc_q << 3) + (tacc_q << 1) + TARE_W'(digit);

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    wacc_d      = wacc_q;
    wneg_d      = wneg_q;
    tacc_d      = tacc_q;
    status_d    = status_q;
    hdr_good_d  = hdr_good_q;
    dig_err_d   = dig_err_q;
    tare_good_d = tare_good_q;
    if (en_i) begin
      if (pos_q == POS_IDLE) begin
        if (byte_i == STX_CODE) begin
          pos_d       = POS_IDLE + 5'd1;
          sum_d       = '0;
          wacc_d      = '0;
          wneg_d      = 1'b0;
          tacc_d      = '0;
          status_d    = '0;
          hdr_good_d  = 1'b1;
          dig_err_d   = 1'b0;
          tare_good_d = 1'b1;
        end
      end else begin
        if (pos_q <= POS_STATUS) begin
          sum_d = sum_q + byte_i;
        end
        if (pos_q <= POS_WEIGHT_END) begin
          if (is_digit(byte_i)) begin
            wacc_d = wacc_next;
          end else if (byte_i == MINUS_CHAR) begin
            wneg_d = 1'b1;
          end else if (byte_i != SPACE_CHAR && byte_i != PLUS_CHAR) begin
            dig_err_d = 1'b1;
          end
        end else if (pos_q == POS_STATUS) begin
          status_d = byte_i;
        end else if (pos_q == POS_ETX) begin
          if (byte_i != ETX_CODE) hdr_good_d = 1'b0;
        end else if (pos_q == POS_CHECKSUM) begin
          if (byte_i != sum_q) hdr_good_d = 1'b0;
        end else if (pos_q == POS_CR) begin
          if (byte_i != CR_CODE) hdr_good_d = 1'b0;
        end else if (pos_q == POS_TARE_MARK) begin
          if (byte_i != TARE_MARK) tare_good_d = 1'b0;
        end else if (pos_q >= POS_TARE_FIRST && pos_q <= POS_TARE_END) begin
          if (is_digit(byte_i)) begin
            tacc_d = tacc_next;
          end else if (byte_i != SPACE_CHAR) begin
            tare_good_d = 1'b0;
          end
        end
        if (pos_q < POS_LAST) begin
          pos_d = pos_q + 5'd1;
        end else begin
          pos_d = POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_IDLE;
      sum_q       <= '0;
      wacc_q      <= '0;
      wneg_q      <= 1'b0;
      tacc_q      <= '0;
      status_q    <= '0;
      hdr_good_q  <= 1'b1;
      dig_err_q   <= 1'b0;
      tare_good_q <= 1'b1;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      wacc_q      <= wacc_d;
      wneg_q      <= wneg_d;
      tacc_q      <= tacc_d;
      status_q    <= status_d;
      hdr_good_q  <= hdr_good_d;
      dig_err_q   <= dig_err_d;
      tare_good_q <= tare_good_d;
    end
  end

  // result of the frame that the current byte closes
  logic                      ok;
  logic                      tp;
  logic signed [WEIGHT_W-1:0] wmag;

  assign last_o = (pos_q >= POS_LAST);
  assign ok     = hdr_good_q && !dig_err_q;
  assign tp     = tare_good_q && (byte_i == CR_CODE);
  assign wmag   = {1'b0, wacc_q};

  always_comb begin
    result_o = '0;
    if (ok) begin
      result_o.weight_value = wneg_q ? -wmag : wmag;
      result_o.tare_value   = tp ? tacc_q : '0;
      result_o.decimals     = status_q[2:0] & DECIMAL_MASK;
      result_o.over_max     = status_q[7];
      result_o.under_min    = status_q[6];
      result_o.is_stable    = status_q[4];
      result_o.is_zero      = status_q[3];
      result_o.tare_present = tp;
      result_o.frame_valid  = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/scale_frame_decoder.sv
// scale_frame_decoder top level: input register, frame parser, result register
// uses sfd_pkg and sfd_frame_parse
//
//   channel | dir | width | contents
//   s_axis  | in  | 8     | one received serial byte
//   m_axis  | out | 48+1  | one decoded frame per closing byte, flag in tuser
//
// a byte waits in the input register until the parser takes it; one byte per cycle
// is sustained except when a stalled result holds back a closing byte; a byte that
// closes a frame (the 18th byte after STX) goes from the input register to the
// result register; a stalled result blocks only a byte that closes the next frame
// reset drops the partial frame and returns to hunting for STX
`default_nettype none

module scale_frame_decoder
  import sfd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [20:0] weight_value, [37:21] tare_value, [40:38] decimals, [41] over_max,
  // [42] under_min, [43] is_stable, [44] is_zero, [45] tare_present, [47:46] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tuser    // [0] frame_valid
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic              out_user_q;

  logic              fire;
  logic              last;
  sfd_result_t       res;

  sfd_frame_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fire),
    .byte_i   (in_byte_q),
    .last_o   (last),
    .result_o (res)
  );

  assign fire          = in_valid_q && (!last || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (fire && last) begin
      out_data_q <= {2'b00, res.tare_present, res.is_zero, res.is_stable,
                     res.under_min, res.over_max, res.decimals, res.tare_value,
                     res.weight_value};
      out_user_q <= res.frame_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

// File: rtl/core/sfd_checker.sv
// port-level checks for scale_frame_decoder, attached by bind
// uses sfd_pkg
`default_nettype none

module sfd_checker
  import sfd_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  // waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("request changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // failed frame reports all fields zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failed frame with nonzero fields");

  // tare is zero when absent
  a_tare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[45] |-> m_axis_tdata[37:21] == '0)
    else $error("tare value without tare section");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
    else $error("nonzero pad bits");

endmodule

bind scale_frame_decoder sfd_checker u_sfd_checker (.*);

`default_nettype wire

// File: dv/scale_frame_decoder_test.sv
// self-checking bench for scale_frame_decoder: serial bytes in, decoded frames out
// a behavioral frame decoder predicts each result; random gaps and stalls on both streams
// depends on sfd_pkg and scale_frame_decoder
`default_nettype none

module scale_frame_decoder_test
  import sfd_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  scale_frame_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [7:0] rx_bytes[$];
  sfd_result_t expected_frames[$];

  // decoder state
  logic [POS_W-1:0]        frame_pos = POS_IDLE;
  logic [7:0]              sum_acc = '0;
  logic [WEIGHT_ACC_W-1:0] weight_acc = '0;
  logic                    weight_neg = 1'b0;
  logic [TARE_W-1:0]       tare_acc = '0;
  logic [7:0]              status_reg = '0;
  logic                    header_ok = 1'b1;
  logic                    weight_bad = 1'b0;
  logic                    tare_ok = 1'b1;

  int unsigned bytes_sent = 0;
  int unsigned frames_seen = 0;
  int unsigned frames_valid = 0;
  int unsigned frames_tare = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int in_hold = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;

  task automatic decode_byte(input logic [7:0] b);
    sfd_result_t res;
    logic is_num;
    logic [7:0] digit;
    is_num = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
    digit = b - ZERO_CHAR;
    if (frame_pos == POS_IDLE) begin
      if (b == STX_CODE) begin
        sum_acc = '0;
        weight_acc = '0;
        weight_neg = 1'b0;
        tare_acc = '0;
        status_reg = '0;
        header_ok = 1'b1;
        weight_bad = 1'b0;
        tare_ok = 1'b1;
        frame_pos = 5'd1;
      end
      return;
    end
    if (frame_pos <= POS_STATUS) begin
      sum_acc = sum_acc + b;
    end
    if (frame_pos <= POS_WEIGHT_END) begin
      if (is_num) begin
        weight_acc = WEIGHT_ACC_W'(weight_acc * 10 + digit);
      end else if (b == MINUS_CHAR) begin
        weight_neg = 1'b1;
      end else if (b != SPACE_CHAR && b != PLUS_CHAR) begin
        weight_bad = 1'b1;
      end
    end else if (frame_pos == POS_STATUS) begin
      status_reg = b;
    end else if (frame_pos == POS_ETX) begin
      if (b != ETX_CODE) header_ok = 1'b0;
    end else if (frame_pos == POS_CHECKSUM) begin
      if (b != sum_acc) header_ok = 1'b0;
    end else if (frame_pos == POS_CR) begin
      if (b != CR_CODE) header_ok = 1'b0;
    end else if (frame_pos == POS_TARE_MARK) begin
      if (b != TARE_MARK) tare_ok = 1'b0;
    end else if (frame_pos >= POS_TARE_FIRST && frame_pos <= POS_TARE_END) begin
      if (is_num) begin
        tare_acc = TARE_W'(tare_acc * 10 + digit);
      end else if (b != SPACE_CHAR) begin
        tare_ok = 1'b0;
      end
    end else if (frame_pos == POS_LAST) begin
      if (b != CR_CODE) tare_ok = 1'b0;
    end
    if (frame_pos != POS_LAST) begin
      frame_pos = frame_pos + 5'd1;
      return;
    end
    frame_pos = POS_IDLE;
    res = '0;
    if (header_ok && !weight_bad) begin
      res.weight_value = weight_neg ? -{1'b0, weight_acc} : {1'b0, weight_acc};
      res.tare_value = tare_ok ? tare_acc : '0;
      res.decimals = status_reg[2:0] & DECIMAL_MASK;
      res.over_max = status_reg[7];
      res.under_min = status_reg[6];
      res.is_stable = status_reg[4];
      res.is_zero = status_reg[3];
      res.tare_present = tare_ok;
      res.frame_valid = 1'b1;
    end
    expected_frames.push_back(res);
  endtask

  // chars are packed first char in the low byte
  task automatic push_frame(input logic [47:0] wchars, input logic [7:0] spare,
                            input logic [7:0] status, input logic [39:0] tchars,
                            input logic [7:0] etx, input logic [7:0] sum_skew,
                            input logic [7:0] cr_a, input logic [7:0] mark,
                            input logic [7:0] cr_b);
    logic [7:0] sum;
    sum = spare + status;
    rx_bytes.push_back(STX_CODE);
    for (int i = 0; i < 6; i++) begin
      rx_bytes.push_back(wchars[8*i +: 8]);
      sum = sum + wchars[8*i +: 8];
    end
    rx_bytes.push_back(spare);
    rx_bytes.push_back(status);
    rx_bytes.push_back(etx);
    rx_bytes.push_back(sum + sum_skew);
    rx_bytes.push_back(cr_a);
    rx_bytes.push_back(mark);
    for (int i = 0; i < 5; i++) begin
      rx_bytes.push_back(tchars[8*i +: 8]);
    end
    rx_bytes.push_back(cr_b);
  endtask

  function automatic logic [7:0] weight_char();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r < 24) return ZERO_CHAR + 8'($urandom_range(0, 9));
    if (r < 26) return SPACE_CHAR;
    if (r < 27) return PLUS_CHAR;
    if (r < 29) return MINUS_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] tare_char();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r < 27) return ZERO_CHAR + 8'($urandom_range(0, 9));
    if (r < 30) return SPACE_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] mostly(input logic [7:0] good);
    return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : good;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata);
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_bytes.pop_front();
          in_hold = draw_wait(in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    sfd_result_t act;
    sfd_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act.weight_value = m_axis_tdata[20:0];
        act.tare_value = m_axis_tdata[37:21];
        act.decimals = m_axis_tdata[40:38];
        act.over_max = m_axis_tdata[41];
        act.under_min = m_axis_tdata[42];
        act.is_stable = m_axis_tdata[43];
        act.is_zero = m_axis_tdata[44];
        act.tare_present = m_axis_tdata[45];
        act.frame_valid = m_axis_tuser;
        frames_seen++;
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected frame result %h", act);
        end else begin
          exp_res = expected_frames.pop_front();
          if (exp_res.frame_valid) frames_valid++;
          if (exp_res.tare_present) frames_tare++;
          if (act.weight_value !== exp_res.weight_value ||
              act.tare_value !== exp_res.tare_value ||
              act.decimals !== exp_res.decimals ||
              act.over_max !== exp_res.over_max ||
              act.under_min !== exp_res.under_min ||
              act.is_stable !== exp_res.is_stable ||
              act.is_zero !== exp_res.is_zero ||
              act.tare_present !== exp_res.tare_present ||
              act.frame_valid !== exp_res.frame_valid) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("frame %0d mismatch: weight %0d/%0d tare %0d/%0d dec %0d/%0d",
                       frames_seen, exp_res.weight_value, act.weight_value,
                       exp_res.tare_value, act.tare_value, exp_res.decimals, act.decimals);
              $display("  flags ovr,und,stb,zro,tare,valid exp %b%b%b%b%b%b act %b%b%b%b%b%b",
                       exp_res.over_max, exp_res.under_min, exp_res.is_stable,
                       exp_res.is_zero, exp_res.tare_present, exp_res.frame_valid,
                       act.over_max, act.under_min, act.is_stable,
                       act.is_zero, act.tare_present, act.frame_valid);
            end
          end
        end
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [47:0] wchars;
    logic [39:0] tchars;
    int unsigned mode;
    // idle noise, then a negative weight with full tare and all status flags
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(8'hA5);
    push_frame({{5{NINE_CHAR}}, MINUS_CHAR}, 8'hFF, 8'hDF, {5{NINE_CHAR}},
               ETX_CODE, 8'h00, CR_CODE, TARE_MARK, CR_CODE);
    while (rx_bytes.size() < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      mode = $urandom_range(0, 15);
      if (mode == 0) begin
        wchars = {6{NINE_CHAR}};
      end else if (mode == 1) begin
        wchars = {{5{ZERO_CHAR}}, MINUS_CHAR};
      end else begin
        for (int i = 0; i < 6; i++) wchars[8*i +: 8] = weight_char();
      end
      if ($urandom_range(0, 15) == 0) begin
        tchars = {5{NINE_CHAR}};
      end else begin
        for (int i = 0; i < 5; i++) tchars[8*i +: 8] = tare_char();
      end
      push_frame(wchars, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), tchars,
                 mostly(ETX_CODE),
                 ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                 mostly(CR_CODE), mostly(TARE_MARK), mostly(CR_CODE));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (rx_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d frame results", bytes_sent, frames_seen);
    $display("%0d frames decoded valid, %0d of them carrying tare", frames_valid, frames_tare);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_frame_parse.sv
rtl/core/scale_frame_decoder.sv
rtl/core/sfd_checker.sv
dv/scale_frame_decoder_test.sv
